FILE: hw/rtl/nss_pkg.sv
// Shared types and constants for the nearest slot search block.
// Used by every module in hw/rtl; depends on nothing else.
package nss_pkg;

    localparam int SLOT_N  = 16;
    localparam int IDX_W   = $clog2(SLOT_N);
    localparam int CNT_W   = 5;
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = 17;
    localparam int TRY_W   = 2 * ROOT_W + 1;
    localparam logic [ROOT_W-1:0] DIST_MAX = 17'd92682;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

FILE: hw/rtl/nss_dist.sv
// Squared distance pipeline: absolute differences, squares, then their sum.
// Three register stages; depends on nss_pkg.
module nss_dist
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  nss_pkg::tag_t                       in_tag,
    input  logic signed [nss_pkg::COORD_W-1:0]  qx,
    input  logic signed [nss_pkg::COORD_W-1:0]  qy,
    input  logic signed [nss_pkg::COORD_W-1:0]  sx,
    input  logic signed [nss_pkg::COORD_W-1:0]  sy,
    output nss_pkg::tag_t                       out_tag,
    output logic [nss_pkg::SUM_W-1:0]           out_sum
);

    nss_pkg::tag_t                  tag_a_reg;
    nss_pkg::tag_t                  tag_b_reg;
    nss_pkg::tag_t                  tag_c_reg;
    logic [nss_pkg::DIFF_W-1:0]     dx_reg;
    logic [nss_pkg::DIFF_W-1:0]     dy_reg;
    logic [nss_pkg::SQ_W-1:0]       sqx_reg;
    logic [nss_pkg::SQ_W-1:0]       sqy_reg;
    logic [nss_pkg::SUM_W-1:0]      sum_reg;
    logic signed [nss_pkg::COORD_W:0] diff_x;
    logic signed [nss_pkg::COORD_W:0] diff_y;
    logic [nss_pkg::DIFF_W-1:0]     abs_x;
    logic [nss_pkg::DIFF_W-1:0]     abs_y;

    always_comb
    begin
        diff_x = {qx[nss_pkg::COORD_W-1], qx} - {sx[nss_pkg::COORD_W-1], sx};
        diff_y = {qy[nss_pkg::COORD_W-1], qy} - {sy[nss_pkg::COORD_W-1], sy};
        abs_x  = nss_pkg::DIFF_W'(diff_x[nss_pkg::COORD_W] ? -diff_x : diff_x);
        abs_y  = nss_pkg::DIFF_W'(diff_y[nss_pkg::COORD_W] ? -diff_y : diff_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else
        begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= abs_x;
        dy_reg  <= abs_y;
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    assign out_tag = tag_c_reg;
    assign out_sum = sum_reg;

endmodule

FILE: hw/rtl/nss_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on nss_pkg.
module nss_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  nss_pkg::tag_t                in_tag,
    input  logic [nss_pkg::SUM_W-1:0]    in_value,
    output nss_pkg::tag_t                out_tag,
    output logic [nss_pkg::ROOT_W-1:0]   out_root
);

    nss_pkg::tag_t               tag_reg  [nss_pkg::ROOT_W];
    logic [nss_pkg::TRY_W-1:0]   rem_reg  [nss_pkg::ROOT_W];
    logic [nss_pkg::ROOT_W-1:0]  root_reg [nss_pkg::ROOT_W];

    for (genvar k = 0; k < nss_pkg::ROOT_W; k++)
    begin : g_stage
        localparam int BIT = nss_pkg::ROOT_W - 1 - k;
        nss_pkg::tag_t              tag_in;
        logic [nss_pkg::TRY_W-1:0]  rem_in;
        logic [nss_pkg::ROOT_W-1:0] root_in;
        logic [nss_pkg::TRY_W-1:0]  trial;
        logic [nss_pkg::TRY_W-1:0]  rem_next;
        logic [nss_pkg::ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign tag_in  = in_tag;
            assign rem_in  = nss_pkg::TRY_W'(in_value);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign tag_in  = tag_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb
        begin
            trial = (nss_pkg::TRY_W'(root_in) << (BIT + 1))
                  | (nss_pkg::TRY_W'(1) << (2 * BIT));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (nss_pkg::ROOT_W'(1) << BIT);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else
            begin
                tag_reg[k] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign out_tag  = tag_reg[nss_pkg::ROOT_W-1];
    assign out_root = root_reg[nss_pkg::ROOT_W-1];

endmodule

FILE: hw/rtl/nearest_slot_search_core.sv
// A load beat writes one slot. A query beat sends slots 0 to n-1, where n is the configured
// slot count clamped to 1..16, through a 21-stage slot read, distance and square root
// pipeline, one slot per cycle. The next beat is taken once the result beat has been
// delivered. Depends on nss_pkg, nss_dist and nss_sqrt.
module nearest_slot_search_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nss_pkg::CNT_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [nss_pkg::IDX_W-1:0]           slot_index,
    input  logic signed [nss_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [nss_pkg::COORD_W-1:0]  pos_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [nss_pkg::IDX_W-1:0]           nearest_index,
    output logic [nss_pkg::ROOT_W-1:0]          nearest_distance
);

    nss_pkg::state_t                   state_reg;
    nss_pkg::state_t                   state_next;
    logic [nss_pkg::CNT_W-1:0]         count_reg;
    logic [nss_pkg::IDX_W-1:0]         cnt_reg;
    logic [nss_pkg::IDX_W-1:0]         cnt_next;
    logic [nss_pkg::IDX_W-1:0]         last_reg;
    logic [nss_pkg::IDX_W-1:0]         last_next;
    logic signed [nss_pkg::COORD_W-1:0] qx_reg;
    logic signed [nss_pkg::COORD_W-1:0] qy_reg;
    logic signed [nss_pkg::COORD_W-1:0] mem_x [nss_pkg::SLOT_N];
    logic signed [nss_pkg::COORD_W-1:0] mem_y [nss_pkg::SLOT_N];
    logic signed [nss_pkg::COORD_W-1:0] rd_x_reg;
    logic signed [nss_pkg::COORD_W-1:0] rd_y_reg;
    nss_pkg::tag_t                     rd_tag_reg;
    nss_pkg::tag_t                     rd_tag_next;
    nss_pkg::tag_t                     dist_tag;
    logic [nss_pkg::SUM_W-1:0]         dist_sum;
    nss_pkg::tag_t                     fin_tag;
    logic [nss_pkg::ROOT_W-1:0]        fin_root;
    logic [nss_pkg::ROOT_W-1:0]        best_d_reg;
    logic [nss_pkg::IDX_W-1:0]         best_i_reg;
    logic [nss_pkg::ROOT_W-1:0]        best_d_next;
    logic [nss_pkg::IDX_W-1:0]         best_i_next;
    logic                              out_valid_reg;
    logic [nss_pkg::ROOT_W-1:0]        out_d_reg;
    logic [nss_pkg::IDX_W-1:0]         out_i_reg;
    logic                              in_accept;
    logic                              take;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != nss_pkg::ST_IDLE) || out_valid_reg;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (count_reg == '0)
        begin
            last_next = '0;
        end
        else if (count_reg > nss_pkg::CNT_W'(nss_pkg::SLOT_N))
        begin
            last_next = nss_pkg::IDX_W'(nss_pkg::SLOT_N - 1);
        end
        else
        begin
            last_next = nss_pkg::IDX_W'(count_reg - 1'b1);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        rd_tag_next       = '0;
        rd_tag_next.idx   = cnt_reg;
        rd_tag_next.first = (cnt_reg == '0);
        rd_tag_next.last  = (cnt_reg == last_reg);
        unique case (state_reg)
            nss_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_accept && kind == nss_pkg::KIND_QUERY)
                begin
                    state_next = nss_pkg::ST_ISSUE;
                end
            end
            nss_pkg::ST_ISSUE:
            begin
                rd_tag_next.valid = 1'b1;
                cnt_next          = cnt_reg + 1'b1;
                if (cnt_reg == last_reg)
                begin
                    state_next = nss_pkg::ST_DRAIN;
                end
            end
            nss_pkg::ST_DRAIN:
            begin
                if (fin_tag.valid && fin_tag.last)
                begin
                    state_next = nss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nss_pkg::ST_IDLE;
            count_reg  <= nss_pkg::CNT_W'(1);
            cnt_reg    <= '0;
            last_reg   <= '0;
            rd_tag_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_tag_reg <= rd_tag_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            if (in_accept)
            begin
                last_reg <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
        end
        if (in_accept && kind == nss_pkg::KIND_LOAD)
        begin
            mem_x[slot_index] <= pos_x;
            mem_y[slot_index] <= pos_y;
        end
        rd_x_reg <= mem_x[cnt_reg];
        rd_y_reg <= mem_y[cnt_reg];
    end

    nss_dist u_dist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (rd_tag_reg),
        .qx      (qx_reg),
        .qy      (qy_reg),
        .sx      (rd_x_reg),
        .sy      (rd_y_reg),
        .out_tag (dist_tag),
        .out_sum (dist_sum)
    );

    nss_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (dist_tag),
        .in_value (dist_sum),
        .out_tag  (fin_tag),
        .out_root (fin_root)
    );

    always_comb
    begin
        best_d_next = best_d_reg;
        best_i_next = best_i_reg;
        if (fin_tag.valid && (fin_tag.first || fin_root < best_d_reg))
        begin
            best_d_next = fin_root;
            best_i_next = fin_tag.idx;
        end
    end

    assign take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_tag.valid && fin_tag.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        if (fin_tag.valid && fin_tag.last)
        begin
            out_d_reg <= best_d_next;
            out_i_reg <= best_i_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign nearest_index    = out_i_reg;
    assign nearest_distance = out_d_reg;

    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fin_tag.valid |-> state_reg == nss_pkg::ST_DRAIN)
        else $error("Distance result arrived while no query was in flight.");

    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fin_tag.valid && fin_tag.last))
        else $error("Result beat raised without the last slot of a query.");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_d_reg <= nss_pkg::DIST_MAX)
        else $error("Result distance exceeds the largest possible distance.");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nss_pkg::ST_ISSUE |=> !in_accept)
        else $error("Input beat accepted while a query was being issued.");

endmodule
